// File: rtl/core/qdma_pkg.sv
package qdma_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int ANGLE_FRAC_BITS = 14;
    localparam int IFB             = 30;
    localparam int MAG_W           = COORD_WIDTH + 1;
    localparam int SHIFT_W         = $clog2(MAG_W + 1);
    localparam int ROUND_SH        = IFB - ANGLE_FRAC_BITS;

    localparam int SQRT_EDGE_STEPS = 32;
    localparam int SQRT_COS_STEPS  = 31;
    localparam int DIV_STEPS       = 31;
    localparam int CORDIC_STEPS    = 30;

    localparam int EDGE_LAT   = 4 + SQRT_EDGE_STEPS + DIV_STEPS + 1;
    localparam int CORNER_LAT = 4 + SQRT_COS_STEPS + 1 + CORDIC_STEPS + 1;
    localparam int PIPE_LAT   = EDGE_LAT + CORNER_LAT + 2;

    localparam logic signed [33:0] HALF_PI_Q = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q      = 34'sd3373259426;

    // Edge k joins corner EDGE_LO[k] to corner EDGE_HI[k].
    localparam int EDGE_LO [6] = '{0, 0, 0, 1, 1, 2};
    localparam int EDGE_HI [6] = '{1, 2, 3, 2, 3, 3};

    // Twelve corner angles, three per triangle: (0,1,3) (1,2,3) (0,1,2) (0,2,3).
    localparam int CORNER_APEX [12] = '{0, 1, 3, 1, 2, 3, 0, 1, 2, 0, 2, 3};
    localparam int CORNER_OA   [12] = '{3, 0, 1, 3, 1, 2, 2, 0, 1, 3, 0, 2};
    localparam int CORNER_OB   [12] = '{1, 3, 0, 2, 3, 1, 1, 2, 0, 2, 3, 0};

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] c0_x;
        logic signed [COORD_WIDTH-1:0] c0_y;
        logic signed [COORD_WIDTH-1:0] c0_z;
        logic signed [COORD_WIDTH-1:0] c1_x;
        logic signed [COORD_WIDTH-1:0] c1_y;
        logic signed [COORD_WIDTH-1:0] c1_z;
        logic signed [COORD_WIDTH-1:0] c2_x;
        logic signed [COORD_WIDTH-1:0] c2_y;
        logic signed [COORD_WIDTH-1:0] c2_z;
        logic signed [COORD_WIDTH-1:0] c3_x;
        logic signed [COORD_WIDTH-1:0] c3_y;
        logic signed [COORD_WIDTH-1:0] c3_z;
    } qdma_in_t;

    typedef struct packed {
        logic        split_choice;
        logic [15:0] best_min_angle;
    } qdma_out_t;

    typedef logic signed [31:0] unit_t;

    typedef struct packed {
        unit_t [2:0] ua;
        unit_t [2:0] ub;
        logic        flip;
        logic        zero;
    } corner_in_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_state_t;

    typedef struct packed {
        logic [2:0][30:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } edge_side_t;

    typedef struct packed {
        logic [2:0][31:0] rem;
        logic [2:0][30:0] q;
        logic [31:0]      len;
        edge_side_t       side;
    } div_t;

    typedef struct packed {
        logic [30:0] ac;
        logic        cneg;
        logic        zero;
    } corner_side_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               zero;
    } cordic_t;

    // One bit of the digit-by-digit square root; k selects the bit pair.
    function automatic sqrt_state_t isqrt_step(sqrt_state_t st, int k);
        logic [63:0] b;
        logic [63:0] t;
        sqrt_state_t nx;
        b = 64'd1 << (2 * k);
        t = st.r + b;
        if (st.v >= t) begin
            nx.v = st.v - t;
            nx.r = (st.r >> 1) + b;
        end else begin
            nx.v = st.v;
            nx.r = st.r >> 1;
        end
        return nx;
    endfunction

    // One quotient bit of restoring division for all three components.
    function automatic div_t div_step(div_t d, logic [2:0] bits);
        logic [32:0] t;
        div_t nx;
        nx = d;
        for (int k = 0; k < 3; k++) begin
            t = {d.rem[k], bits[k]};
            if (t >= {1'b0, d.len}) begin
                nx.rem[k] = 32'(t - {1'b0, d.len});
                nx.q[k]   = {d.q[k][29:0], 1'b1};
            end else begin
                nx.rem[k] = t[31:0];
                nx.q[k]   = {d.q[k][29:0], 1'b0};
            end
        end
        return nx;
    endfunction

    function automatic logic signed [33:0] atan_step(int i);
        case (i)
            0:       return 34'sh03243F6A9;
            1:       return 34'sh01DAC6705;
            2:       return 34'sh00FADBAFD;
            3:       return 34'sh007F56EA7;
            4:       return 34'sh003FEAB77;
            5:       return 34'sh001FFD55C;
            6:       return 34'sh000FFFAAB;
            7:       return 34'sh0007FFF55;
            8:       return 34'sh0003FFFEB;
            9:       return 34'sh0001FFFFD;
            default: return 34'sd1 <<< (IFB - i);
        endcase
    endfunction

    function automatic cordic_t cordic_step(cordic_t st, int i);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        cordic_t nx;
        dx = st.y >>> i;
        dy = st.x >>> i;
        nx = st;
        if (st.y > 0) begin
            nx.x = st.x + dx;
            nx.y = st.y - dy;
            nx.z = st.z + atan_step(i);
        end else if (st.y < 0) begin
            nx.x = st.x - dx;
            nx.y = st.y + dy;
            nx.z = st.z - atan_step(i);
        end
        return nx;
    endfunction

    // Round half up to the output fraction width and saturate.
    function automatic logic [15:0] round_angle(logic [31:0] win);
        logic [32:0] r;
        if (ROUND_SH <= 0) begin
            r = {1'b0, win};
        end else begin
            r = ({1'b0, win} + (33'd1 << (ROUND_SH - 1))) >> ROUND_SH;
        end
        return (r > 33'h0FFFF) ? 16'hFFFF : r[15:0];
    endfunction

    localparam logic [15:0] ANGLE_OUT_MAX = round_angle(PI_Q[31:0]);

endpackage

// File: rtl/core/quad_diagonal_max_min_angle.sv
// Channel  Ports                      Direction  Beat
// s_       s_valid s_ready s_data     in         one quad: four corners, x y z each
// m_       m_valid m_ready m_data     out        split choice and its min angle
//
// One beat enters per cycle while the pipeline is not held (see below); results leave in the order of their beats.
// The latency is set by the edge unit (square root, 32 stages; division, 31 stages)
// followed by the corner unit (square root, 31 stages; arctangent, 30 stages).
// aresetn is synchronous and active low; it clears only the valid bits.
// When a result waits at m_ with m_ready low, the whole pipeline holds, s_ready
// drops, and nothing moves until the result is taken.
module quad_diagonal_max_min_angle
    import qdma_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  qdma_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output qdma_out_t m_data
);

    logic                   en;
    logic [PIPE_LAT-1:0]    vld_reg;

    logic signed [COORD_WIDTH-1:0] pt [4][3];
    unit_t                  edge_u    [6][3];
    logic                   edge_zero [6];
    logic [31:0]            angle_w   [12];

    logic [31:0]            tri_min_reg [4];
    qdma_out_t              out_reg;

    assign en      = !vld_reg[PIPE_LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_LAT-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_comb begin
        pt[0][0] = s_data.c0_x;  pt[0][1] = s_data.c0_y;  pt[0][2] = s_data.c0_z;
        pt[1][0] = s_data.c1_x;  pt[1][1] = s_data.c1_y;  pt[1][2] = s_data.c1_z;
        pt[2][0] = s_data.c2_x;  pt[2][1] = s_data.c2_y;  pt[2][2] = s_data.c2_z;
        pt[3][0] = s_data.c3_x;  pt[3][1] = s_data.c3_y;  pt[3][2] = s_data.c3_z;
    end

    // Unit vector of each edge, pointing from the lower to the higher corner.
    for (genvar e = 0; e < 6; e++) begin : g_edge
        localparam int LO = EDGE_LO[e];
        localparam int HI = EDGE_HI[e];

        logic [2:0]             neg1_reg;
        logic [MAG_W-1:0]       mag1_reg [3];
        edge_side_t             side2_reg;
        logic [61:0]            sq3_reg [3];
        edge_side_t             side3_reg;
        sqrt_state_t            st_reg   [SQRT_EDGE_STEPS+1];
        edge_side_t             side_reg [SQRT_EDGE_STEPS+1];
        div_t                   div_reg  [DIV_STEPS];
        unit_t                  u_reg    [3];
        logic                   zero_reg;

        logic signed [MAG_W-1:0] diff [3];
        logic [MAG_W-1:0]       maxm;
        logic [SHIFT_W-1:0]     sh;
        edge_side_t             side2_next;
        div_t                   div_in;
        logic [2:0]             first_bits;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                diff[k] = $signed({pt[HI][k][COORD_WIDTH-1], pt[HI][k]})
                        - $signed({pt[LO][k][COORD_WIDTH-1], pt[LO][k]});
            end
        end

        // Common right shift that brings the largest magnitude below 2^31.
        always_comb begin
            maxm = mag1_reg[0];
            if (mag1_reg[1] > maxm) begin
                maxm = mag1_reg[1];
            end
            if (mag1_reg[2] > maxm) begin
                maxm = mag1_reg[2];
            end
            sh = '0;
            for (int j = 31; j < MAG_W; j++) begin
                if (maxm[j]) begin
                    sh = SHIFT_W'(j - 30);
                end
            end
            for (int k = 0; k < 3; k++) begin
                side2_next.mag[k] = 31'(mag1_reg[k] >> sh);
            end
            side2_next.neg  = neg1_reg;
            side2_next.zero = (maxm == '0);
        end

        // Quotient is at most 2^30, so the dividend's upper bits start as the remainder.
        always_comb begin
            div_in.len  = st_reg[SQRT_EDGE_STEPS].r[31:0];
            div_in.side = side_reg[SQRT_EDGE_STEPS];
            for (int k = 0; k < 3; k++) begin
                div_in.rem[k] = {2'b00, side_reg[SQRT_EDGE_STEPS].mag[k][30:1]};
                div_in.q[k]   = '0;
                first_bits[k] = side_reg[SQRT_EDGE_STEPS].mag[k][0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    neg1_reg[k] <= diff[k][MAG_W-1];
                    mag1_reg[k] <= diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
                end

                side2_reg <= side2_next;

                for (int k = 0; k < 3; k++) begin
                    sq3_reg[k] <= 62'(side2_reg.mag[k]) * 62'(side2_reg.mag[k]);
                end
                side3_reg <= side2_reg;

                st_reg[0].v <= 64'(sq3_reg[0]) + 64'(sq3_reg[1]) + 64'(sq3_reg[2]);
                st_reg[0].r <= '0;
                side_reg[0] <= side3_reg;
                for (int j = 0; j < SQRT_EDGE_STEPS; j++) begin
                    st_reg[j+1]   <= isqrt_step(st_reg[j], SQRT_EDGE_STEPS - 1 - j);
                    side_reg[j+1] <= side_reg[j];
                end

                div_reg[0] <= div_step(div_in, first_bits);
                for (int j = 1; j < DIV_STEPS; j++) begin
                    div_reg[j] <= div_step(div_reg[j-1], 3'b000);
                end

                for (int k = 0; k < 3; k++) begin
                    if (div_reg[DIV_STEPS-1].side.neg[k]) begin
                        u_reg[k] <= -$signed({1'b0, div_reg[DIV_STEPS-1].q[k]});
                    end else begin
                        u_reg[k] <= $signed({1'b0, div_reg[DIV_STEPS-1].q[k]});
                    end
                end
                zero_reg <= div_reg[DIV_STEPS-1].side.zero;
            end
        end

        for (genvar k = 0; k < 3; k++) begin : g_comp
            assign edge_u[e][k] = u_reg[k];
        end
        assign edge_zero[e] = zero_reg;
    end

    // Corner angle at the apex between the edges that meet there; a reversed edge negates the cosine.
    for (genvar c = 0; c < 12; c++) begin : g_corner
        localparam int P  = CORNER_APEX[c];
        localparam int QA = CORNER_OA[c];
        localparam int QB = CORNER_OB[c];
        localparam int EA = (P < QA) ? ((P == 0) ? QA - 1 : (P == 1) ? QA + 1 : 5)
                                     : ((QA == 0) ? P - 1 : (QA == 1) ? P + 1 : 5);
        localparam int EB = (P < QB) ? ((P == 0) ? QB - 1 : (P == 1) ? QB + 1 : 5)
                                     : ((QB == 0) ? P - 1 : (QB == 1) ? P + 1 : 5);

        corner_in_t cin;

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                cin.ua[k] = edge_u[EA][k];
                cin.ub[k] = edge_u[EB][k];
            end
            cin.flip = (P > QA) != (P > QB);
            cin.zero = edge_zero[EA] || edge_zero[EB];
        end

        qdma_corner u_corner (
            .aclk      (aclk),
            .en        (en),
            .corner_in (cin),
            .angle     (angle_w[c])
        );
    end

    logic [31:0] tri_min_next [4];
    logic [31:0] score_a;
    logic [31:0] score_b;
    logic        choice;

    always_comb begin
        for (int t = 0; t < 4; t++) begin
            tri_min_next[t] = angle_w[3*t];
            if (angle_w[3*t+1] < tri_min_next[t]) begin
                tri_min_next[t] = angle_w[3*t+1];
            end
            if (angle_w[3*t+2] < tri_min_next[t]) begin
                tri_min_next[t] = angle_w[3*t+2];
            end
        end
        score_a = (tri_min_reg[0] > tri_min_reg[1]) ? tri_min_reg[0] : tri_min_reg[1];
        score_b = (tri_min_reg[2] > tri_min_reg[3]) ? tri_min_reg[2] : tri_min_reg[3];
        // Ties go to the second split.
        choice  = !(score_a > score_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tri_min_reg            <= tri_min_next;
            out_reg.split_choice   <= choice;
            out_reg.best_min_angle <= round_angle(choice ? score_b : score_a);
        end
    end

    a_reset_empties: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_tri_min_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PIPE_LAT-2] |-> (tri_min_reg[0] <= PI_Q[31:0]) && (tri_min_reg[1] <= PI_Q[31:0])
            && (tri_min_reg[2] <= PI_Q[31:0]) && (tri_min_reg[3] <= PI_Q[31:0]))
        else $error("triangle minimum above pi");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.best_min_angle <= ANGLE_OUT_MAX)
        else $error("result angle above pi");

endmodule

// File: rtl/core/qdma_corner.sv
module qdma_corner
    import qdma_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  corner_in_t  corner_in,
    output logic [31:0] angle
);

    logic signed [63:0] prod_reg [3];
    logic               flip1_reg;
    logic               zero1_reg;

    logic signed [31:0] c_reg;
    logic               flip2_reg;
    logic               zero2_reg;

    logic [60:0]        sq_reg;
    corner_side_t       side3_reg;

    sqrt_state_t        st_reg    [SQRT_COS_STEPS+1];
    corner_side_t       cside_reg [SQRT_COS_STEPS+1];
    cordic_t            cd_reg    [CORDIC_STEPS+1];
    logic [31:0]        angle_reg;

    logic signed [65:0] dot;
    logic signed [65:0] tq;
    logic signed [31:0] c_next;
    logic [30:0]        ac;
    logic               cneg;
    cordic_t            cd_init;

    always_comb begin
        dot = {{2{prod_reg[0][63]}}, prod_reg[0]} + {{2{prod_reg[1][63]}}, prod_reg[1]}
            + {{2{prod_reg[2][63]}}, prod_reg[2]};
        // Divide by 2^IFB truncating toward zero, then clamp to the range minus one to one.
        if (dot < 0) begin
            tq = (dot + 66'sd1073741823) >>> IFB;
        end else begin
            tq = dot >>> IFB;
        end
        if (tq > 66'sd1073741824) begin
            c_next = 32'sd1073741824;
        end else if (tq < -66'sd1073741824) begin
            c_next = -32'sd1073741824;
        end else begin
            c_next = tq[31:0];
        end
    end

    // The edge orientation only flips the cosine's sign, not its magnitude.
    always_comb begin
        ac   = (c_reg < 0) ? 31'(-c_reg) : 31'(c_reg);
        cneg = (c_reg != 0) && ((c_reg < 0) != flip2_reg);
    end

    always_comb begin
        cd_init.zero = cside_reg[SQRT_COS_STEPS].zero;
        if (cside_reg[SQRT_COS_STEPS].cneg) begin
            cd_init.x = 34'($signed({1'b0, st_reg[SQRT_COS_STEPS].r[30:0]}));
            cd_init.y = 34'($signed({1'b0, cside_reg[SQRT_COS_STEPS].ac}));
            cd_init.z = HALF_PI_Q;
        end else begin
            cd_init.x = 34'($signed({1'b0, cside_reg[SQRT_COS_STEPS].ac}));
            cd_init.y = 34'($signed({1'b0, st_reg[SQRT_COS_STEPS].r[30:0]}));
            cd_init.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= $signed(corner_in.ua[k]) * $signed(corner_in.ub[k]);
            end
            flip1_reg <= corner_in.flip;
            zero1_reg <= corner_in.zero;

            c_reg     <= c_next;
            flip2_reg <= flip1_reg;
            zero2_reg <= zero1_reg;

            sq_reg          <= 61'(ac) * 61'(ac);
            side3_reg.ac    <= ac;
            side3_reg.cneg  <= cneg;
            side3_reg.zero  <= zero2_reg;

            st_reg[0].v  <= (64'd1 << (2 * IFB)) - 64'(sq_reg);
            st_reg[0].r  <= '0;
            cside_reg[0] <= side3_reg;
            for (int j = 0; j < SQRT_COS_STEPS; j++) begin
                st_reg[j+1]    <= isqrt_step(st_reg[j], SQRT_COS_STEPS - 1 - j);
                cside_reg[j+1] <= cside_reg[j];
            end

            cd_reg[0] <= cd_init;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                cd_reg[i+1] <= cordic_step(cd_reg[i], i);
            end

            if (cd_reg[CORDIC_STEPS].zero || cd_reg[CORDIC_STEPS].z < 0) begin
                angle_reg <= '0;
            end else if (cd_reg[CORDIC_STEPS].z > PI_Q) begin
                angle_reg <= PI_Q[31:0];
            end else begin
                angle_reg <= cd_reg[CORDIC_STEPS].z[31:0];
            end
        end
    end

    assign angle = angle_reg;

endmodule

// File: test/testbench.sv
module testbench
    import qdma_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [63:0] ONE_Q = 64'sd1 << 30;
    localparam logic signed [63:0] PI_VAL = 64'sd3373259426;
    localparam logic signed [63:0] HALF_PI_VAL = 64'sd1686629713;
    localparam int N_RANDOM = 530;
    localparam int N_DIRECTED = 12;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    qdma_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    qdma_out_t m_data;

    qdma_out_t expected_angles[$];
    int        errors;
    bit        quiet_tail;

    quad_diagonal_max_min_angle DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] arctan_term(int i);
        logic signed [63:0] t [10];
        t = '{64'h3243F6A9, 64'h1DAC6705, 64'h0FADBAFD, 64'h07F56EA7, 64'h03FEAB77,
              64'h01FFD55C, 64'h00FFFAAB, 64'h007FFF55, 64'h003FFFEB, 64'h001FFFFD};
        if (i < 10) return t[i];
        return 64'sd1 << (30 - i);
    endfunction

    function automatic logic signed [63:0] arccos_q30(logic signed [63:0] c);
        logic [63:0] ac;
        logic signed [63:0] x, y, z, dx, dy;
        ac = (c < 0) ? -c : c;
        if (c < 0) begin
            x = int_sqrt((64'd1 << 60) - ac * ac);
            y = -c;
            z = HALF_PI_VAL;
        end else begin
            x = c;
            y = int_sqrt((64'd1 << 60) - ac * ac);
            z = 0;
        end
        for (int i = 0; i < 30; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx; y = y - dy; z = z + arctan_term(i);
            end else if (y < 0) begin
                x = x - dx; y = y + dy; z = z - arctan_term(i);
            end
        end
        if (z < 0) z = 0;
        if (z > PI_VAL) z = PI_VAL;
        return z;
    endfunction

    // Unit vector from corner p toward corner q, Q.30; returns 0 on a zero-length edge.
    function automatic bit unit_edge(logic signed [63:0] p[3], logic signed [63:0] q[3],
                                     output logic signed [63:0] u[3]);
        logic [63:0] mag[3];
        logic [63:0] maxm, sum, len, quo;
        int s;
        maxm = 0;
        sum = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (q[k] < p[k]) ? p[k] - q[k] : q[k] - p[k];
            if (mag[k] > maxm) maxm = mag[k];
        end
        if (maxm == 0) return 0;
        while ((maxm >> s) >= (64'd1 << 31)) s++;
        for (int k = 0; k < 3; k++) begin
            mag[k] = mag[k] >> s;
            sum = sum + mag[k] * mag[k];
        end
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++) begin
            quo = (mag[k] << 30) / len;
            u[k] = (q[k] < p[k]) ? -$signed(quo) : $signed(quo);
        end
        return 1;
    endfunction

    function automatic logic signed [63:0] apex_angle(logic signed [63:0] c[4][3],
                                                      int p, int a, int b);
        logic signed [63:0] ua[3], ub[3];
        logic signed [63:0] dot, cs;
        if (!unit_edge(c[p], c[a], ua)) return 0;
        if (!unit_edge(c[p], c[b], ub)) return 0;
        dot = ua[0] * ub[0] + ua[1] * ub[1] + ua[2] * ub[2];
        cs = dot / ONE_Q;
        if (cs > ONE_Q) cs = ONE_Q;
        if (cs < -ONE_Q) cs = -ONE_Q;
        return arccos_q30(cs);
    endfunction

    function automatic logic signed [63:0] smallest_angle(logic signed [63:0] c[4][3],
                                                          int a, int b, int d);
        logic signed [63:0] m, t;
        m = apex_angle(c, a, d, b);
        t = apex_angle(c, b, a, d);
        if (t < m) m = t;
        t = apex_angle(c, d, b, a);
        if (t < m) m = t;
        return m;
    endfunction

    function automatic qdma_out_t predict_split(qdma_in_t f);
        logic signed [63:0] c[4][3];
        logic signed [63:0] m0, m1, sa, sb, win, r;
        logic [COORD_WIDTH*12-1:0] flat;
        qdma_out_t o;
        flat = f;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                c[i][k] = $signed(flat[COORD_WIDTH*(12 - i*3 - k) - 1 -: COORD_WIDTH]);
        m0 = smallest_angle(c, 0, 1, 3);
        m1 = smallest_angle(c, 1, 2, 3);
        sa = (m0 > m1) ? m0 : m1;
        m0 = smallest_angle(c, 0, 1, 2);
        m1 = smallest_angle(c, 0, 2, 3);
        sb = (m0 > m1) ? m0 : m1;
        o.split_choice = (sa > sb) ? 1'b0 : 1'b1;
        win = o.split_choice ? sb : sa;
        r = (win + (64'sd1 << 15)) >>> 16;
        if (r > 64'hFFFF) r = 64'hFFFF;
        o.best_min_angle = r[15:0];
        return o;
    endfunction

    function automatic qdma_in_t make_face(logic signed [31:0] v[12]);
        qdma_in_t f;
        f = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], v[9], v[10], v[11]};
        return f;
    endfunction

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8)) - 4;
            2: return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8;
        endcase
    endfunction

    task automatic send_face(qdma_in_t f, bit has_fixed, qdma_out_t fixed_result);
        qdma_out_t p;
        p = predict_split(f);
        if (has_fixed && p !== fixed_result)
            $display("%0t: table row disagrees with predictor: expected %h, predicted %h",
                     $time, fixed_result, p);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_data <= f;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_angles.insert(expected_angles.size(), has_fixed ? fixed_result : p);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_angles.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                qdma_out_t e;
                e = expected_angles.pop_front();
                if (m_data.split_choice !== e.split_choice) begin
                    $display("%0t: split_choice expected %0d actual %0d",
                             $time, e.split_choice, m_data.split_choice);
                    errors++;
                end
                if (m_data.best_min_angle !== e.best_min_angle) begin
                    $display("%0t: best_min_angle expected %0d actual %0d",
                             $time, e.best_min_angle, m_data.best_min_angle);
                    errors++;
                end
            end
        end
    end

    // Result side stalls in bursts until the quiet tail.
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #20ms;
        $display("quad_diagonal_max_min_angle regression: fail");
        $finish;
    end

    initial begin
        logic signed [31:0] v[12];
        logic signed [31:0] rows[N_DIRECTED][12];
        bit                 fixed[N_DIRECTED];
        qdma_out_t          answer[N_DIRECTED];
        int                 mode;
        errors = 0;
        quiet_tail = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        // Fixed answers: all-coincident corners give angle 0 and a tie, so split 1.
        rows[0]  = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        rows[1]  = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
        rows[2]  = '{0, 0, 0, 65536, 0, 0, 65536, 65536, 0, 0, 65536, 0};
        rows[3]  = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
        rows[4]  = '{32'sh80000000, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 32'sh80000000, 0,
                     32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                     32'sh7FFFFFFF, 32'sh80000000};
        rows[5]  = '{0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 65536, 0};
        rows[6]  = '{0, 0, 0, 65536, 0, 0, 131072, 0, 0, 196608, 0, 0};
        rows[7]  = '{0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0};
        rows[8]  = '{0, 0, 0, 4 * 65536, 0, 0, 4 * 65536, 65536, 0, 0, 65536, 0};
        rows[9]  = '{0, 0, 0, 65536, 0, 0, 65536, 65536, 65536, 0, 0, 65536};
        rows[10] = '{0, 0, 0, 65536, 0, 0, 3 * 65536, 65536, 0, 0, 65536, 0};
        rows[11] = '{-65536, -65536, -65536, -65536, 65536, 0, 65536, 65536, 65536,
                     65536, -65536, 0};
        for (int i = 0; i < N_DIRECTED; i++) fixed[i] = 0;
        fixed[0] = 1;
        answer[0] = '{split_choice: 1'b1, best_min_angle: 16'd0};
        fixed[1] = 1;
        answer[1] = '{split_choice: 1'b1, best_min_angle: 16'd0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_face(make_face(rows[i]), fixed[i], answer[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 60) quiet_tail = 1;
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 12; k++) v[k] = rand_coord(mode);
            // Sometimes make two corners coincide.
            if ($urandom_range(0, 9) == 0) begin
                int a, b;
                a = $urandom_range(0, 3);
                b = $urandom_range(0, 3);
                for (int k = 0; k < 3; k++) v[b*3 + k] = v[a*3 + k];
            end
            send_face(make_face(v), 0, '0);
        end
        s_valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge aclk);
        repeat (PIPE_LAT + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("quad_diagonal_max_min_angle regression: pass");
        end else begin
            $display("quad_diagonal_max_min_angle regression: fail");
        end
        $finish;
    end
endmodule
